### sv/pfma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfma_pkg
// Shared types and constants of the pressure force and moment accumulator:
// request structs, controller command and status groups, operand codes.
// ----------------------------------------------------------------------------
package pfma_pkg;

  // fixed-point format defaults
  localparam int FRACTION_BITS_DEF = 16;

  // datapath widths
  localparam int WORD_W   = 32;               // Q16.16 inputs and registers
  localparam int OPB_W    = WORD_W + 1;       // differences and b operands
  localparam int SUM_W    = 64;               // Q48.16 sums
  localparam int HALF_W   = SUM_W / 2;        // one slice of the a operand
  localparam int PP_W     = 2 * OPB_W;        // one partial product
  localparam int PROD_W   = SUM_W + OPB_W;    // full product

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration registers
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd4;

  localparam logic signed [WORD_W-1:0] DENSITY_RESET = 32'sd65536;

  // input request: one boundary face
  typedef struct packed {
    logic signed [WORD_W-1:0] face_pressure;
    logic signed [WORD_W-1:0] area_x;
    logic signed [WORD_W-1:0] area_y;
    logic signed [WORD_W-1:0] area_z;
    logic signed [WORD_W-1:0] centre_x;
    logic signed [WORD_W-1:0] centre_y;
    logic signed [WORD_W-1:0] centre_z;
    logic                     last_face;
  } pfma_in_t;

  // output request: patch totals
  typedef struct packed {
    logic signed [SUM_W-1:0] force_x;
    logic signed [SUM_W-1:0] force_y;
    logic signed [SUM_W-1:0] force_z;
    logic signed [SUM_W-1:0] moment_x;
    logic signed [SUM_W-1:0] moment_y;
    logic signed [SUM_W-1:0] moment_z;
    logic                    overflow;
  } pfma_out_t;

  // multiplier a operand
  typedef enum logic [2:0] {
    ASEL_RHO,
    ASEL_Q,
    ASEL_F0,
    ASEL_F1,
    ASEL_F2
  } pfma_asel_t;

  // multiplier b operand
  typedef enum logic [2:0] {
    BSEL_DP,
    BSEL_S0,
    BSEL_S1,
    BSEL_S2,
    BSEL_L0,
    BSEL_L1,
    BSEL_L2
  } pfma_bsel_t;

  // destination of a finished product
  typedef enum logic [2:0] {
    DST_Q,
    DST_F0,
    DST_F1,
    DST_F2,
    DST_T,
    DST_P2
  } pfma_dst_t;

  // saturating adder operation
  typedef enum logic [1:0] {
    AOP_FORCE,
    AOP_MSUB,
    AOP_MOMENT
  } pfma_aop_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_fin;
    pfma_asel_t asel;
    pfma_bsel_t bsel;
    pfma_dst_t  dst;
    logic       add_en;
    pfma_aop_t  aop;
    logic [1:0] aidx;
    logic       emit;
  } pfma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_face;
    logic out_free;
  } pfma_sts_t;

endpackage

### sv/pfma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfma_ctrl
// Sequencer for one face: walks a fixed list of products and saturating
// adds, then hands the totals to the output register on the last face.
// ----------------------------------------------------------------------------
module pfma_ctrl import pfma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pfma_sts_t sts,
  output pfma_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_MFIN,
    S_ADD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_PROD,
    K_ADD,
    K_DONE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    pfma_asel_t asel;
    pfma_bsel_t bsel;
    pfma_dst_t  dst;
    pfma_aop_t  aop;
    logic [1:0] idx;
  } step_t;

  function automatic step_t mk_prod(input pfma_asel_t a, input pfma_bsel_t b,
                                    input pfma_dst_t d);
    step_t e;
    e      = '0;
    e.kind = K_PROD;
    e.asel = a;
    e.bsel = b;
    e.dst  = d;
    return e;
  endfunction

  function automatic step_t mk_add(input pfma_aop_t op, input logic [1:0] i);
    step_t e;
    e      = '0;
    e.kind = K_ADD;
    e.aop  = op;
    e.idx  = i;
    return e;
  endfunction

  // per-face program: pressure scale, forces, force sums, then three moments
  function automatic step_t prog(input logic [4:0] s);
    step_t e;
    e      = '0;
    e.kind = K_DONE;
    case (s)
      5'd0:  e = mk_prod(ASEL_RHO, BSEL_DP, DST_Q);
      5'd1:  e = mk_prod(ASEL_Q, BSEL_S0, DST_F0);
      5'd2:  e = mk_prod(ASEL_Q, BSEL_S1, DST_F1);
      5'd3:  e = mk_prod(ASEL_Q, BSEL_S2, DST_F2);
      5'd4:  e = mk_add(AOP_FORCE, 2'd0);
      5'd5:  e = mk_add(AOP_FORCE, 2'd1);
      5'd6:  e = mk_add(AOP_FORCE, 2'd2);
      // moment x: ly*fz - lz*fy
      5'd7:  e = mk_prod(ASEL_F2, BSEL_L1, DST_T);
      5'd8:  e = mk_prod(ASEL_F1, BSEL_L2, DST_P2);
      5'd9:  e = mk_add(AOP_MSUB, 2'd0);
      5'd10: e = mk_add(AOP_MOMENT, 2'd0);
      // moment y: lz*fx - lx*fz
      5'd11: e = mk_prod(ASEL_F0, BSEL_L2, DST_T);
      5'd12: e = mk_prod(ASEL_F2, BSEL_L0, DST_P2);
      5'd13: e = mk_add(AOP_MSUB, 2'd1);
      5'd14: e = mk_add(AOP_MOMENT, 2'd1);
      // moment z: lx*fy - ly*fx
      5'd15: e = mk_prod(ASEL_F1, BSEL_L0, DST_T);
      5'd16: e = mk_prod(ASEL_F0, BSEL_L1, DST_P2);
      5'd17: e = mk_add(AOP_MSUB, 2'd2);
      5'd18: e = mk_add(AOP_MOMENT, 2'd2);
      default: e.kind = K_DONE;
    endcase
    return e;
  endfunction

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  step_t      cur;
  step_t      upcoming;
  state_t     adv_state;

  assign cur      = prog(step_r);
  assign upcoming = prog(step_r + 5'd1);

  // state entered when moving on to the next step
  always_comb begin
    case (upcoming.kind)
      K_PROD:  adv_state = S_MLO;
      K_ADD:   adv_state = S_ADD;
      default: adv_state = sts.last_face ? S_EMIT : S_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // the program opens with a product
          state_nxt = S_MLO;
          step_nxt  = 5'd0;
        end
      end
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_MFIN;
      S_MFIN, S_ADD: begin
        state_nxt = adv_state;
        step_nxt  = step_r + 5'd1;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 5'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.mul_lo  = (state_r == S_MLO);
    cmd.mul_hi  = (state_r == S_MHI);
    cmd.mul_fin = (state_r == S_MFIN);
    cmd.asel    = cur.asel;
    cmd.bsel    = cur.bsel;
    cmd.dst     = cur.dst;
    cmd.add_en  = (state_r == S_ADD);
    cmd.aop     = cur.aop;
    cmd.aidx    = cur.idx;
    cmd.emit    = (state_r == S_EMIT) && sts.out_free;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### sv/pfma_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfma_dp
// Datapath: configuration registers, face registers, one shared 33x33
// multiplier with shift and saturate, one saturating adder, the six sums
// and the output register.
// ----------------------------------------------------------------------------
module pfma_dp import pfma_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfma_in_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  pfma_cmd_t            cmd,
  output pfma_sts_t            sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfma_out_t            out_data
);

  // configuration
  logic signed [WORD_W-1:0] rho_r, pref_r, cofr_x_r, cofr_y_r, cofr_z_r;

  // face registers
  logic signed [OPB_W-1:0]  dp_r, l0_r, l1_r, l2_r;
  logic signed [WORD_W-1:0] s0_r, s1_r, s2_r;
  logic                     last_r;

  // intermediates
  logic signed [SUM_W-1:0] q_r, f0_r, f1_r, f2_r, tmp_r, p2_r, m_r;
  logic signed [PP_W-1:0]  pp_r, lo_r;

  // sums and output
  logic signed [SUM_W-1:0] fsx_r, fsy_r, fsz_r, msx_r, msy_r, msz_r;
  logic                    sat_r;
  pfma_out_t               out_r;
  logic                    out_valid_r;

  logic signed [SUM_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [OPB_W-1:0]  mul_a;
  logic signed [PP_W-1:0]   pp_prod;
  logic signed [PROD_W-1:0] full;
  logic signed [PROD_W-1:0] shifted;
  logic                     fin_fits;
  logic signed [SUM_W-1:0]  fin_res;

  logic signed [SUM_W-1:0] add_x, add_y;
  logic signed [SUM_W:0]   add_wide;
  logic                    add_ovf;
  logic signed [SUM_W-1:0] add_res;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_r    <= DENSITY_RESET;
      pref_r   <= '0;
      cofr_x_r <= '0;
      cofr_y_r <= '0;
      cofr_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DENSITY:  rho_r    <= cfg_data;
        CFG_PRESSURE: pref_r   <= cfg_data;
        CFG_CENTRE_X: cofr_x_r <= cfg_data;
        CFG_CENTRE_Y: cofr_y_r <= cfg_data;
        CFG_CENTRE_Z: cofr_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // face capture: pressure difference and lever arm are exact 33-bit values
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dp_r   <= {in_data.face_pressure[WORD_W-1], in_data.face_pressure}
                - {pref_r[WORD_W-1], pref_r};
      l0_r   <= {in_data.centre_x[WORD_W-1], in_data.centre_x}
                - {cofr_x_r[WORD_W-1], cofr_x_r};
      l1_r   <= {in_data.centre_y[WORD_W-1], in_data.centre_y}
                - {cofr_y_r[WORD_W-1], cofr_y_r};
      l2_r   <= {in_data.centre_z[WORD_W-1], in_data.centre_z}
                - {cofr_z_r[WORD_W-1], cofr_z_r};
      s0_r   <= in_data.area_x;
      s1_r   <= in_data.area_y;
      s2_r   <= in_data.area_z;
      last_r <= in_data.last_face;
    end
  end

  // operand select
  always_comb begin
    case (cmd.asel)
      ASEL_RHO: opa = {{(SUM_W-WORD_W){rho_r[WORD_W-1]}}, rho_r};
      ASEL_Q:   opa = q_r;
      ASEL_F0:  opa = f0_r;
      ASEL_F1:  opa = f1_r;
      ASEL_F2:  opa = f2_r;
      default:  opa = q_r;
    endcase
    case (cmd.bsel)
      BSEL_DP: opb = dp_r;
      BSEL_S0: opb = {s0_r[WORD_W-1], s0_r};
      BSEL_S1: opb = {s1_r[WORD_W-1], s1_r};
      BSEL_S2: opb = {s2_r[WORD_W-1], s2_r};
      BSEL_L0: opb = l0_r;
      BSEL_L1: opb = l1_r;
      BSEL_L2: opb = l2_r;
      default: opb = dp_r;
    endcase
  end

  // shared multiplier: low slice unsigned, high slice signed
  assign mul_a   = cmd.mul_hi ? {opa[SUM_W-1], opa[SUM_W-1:HALF_W]}
                              : {1'b0, opa[HALF_W-1:0]};
  assign pp_prod = PP_W'(mul_a) * PP_W'(opb);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp_r <= pp_prod;
    end
    if (cmd.mul_hi) begin
      lo_r <= pp_r;
    end
  end

  // combine slices, floor shift, saturate to 64 bits
  assign full     = {{(PROD_W-PP_W){lo_r[PP_W-1]}}, lo_r}
                    + {pp_r[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
  assign shifted  = full >>> FRACTION_BITS;
  assign fin_fits = (&shifted[PROD_W-1:SUM_W-1]) | ~(|shifted[PROD_W-1:SUM_W-1]);
  assign fin_res  = fin_fits ? shifted[SUM_W-1:0]
                             : (shifted[PROD_W-1] ? SUM_MIN : SUM_MAX);

  always_ff @(posedge clk) begin
    if (cmd.mul_fin) begin
      case (cmd.dst)
        DST_Q:   q_r   <= fin_res;
        DST_F0:  f0_r  <= fin_res;
        DST_F1:  f1_r  <= fin_res;
        DST_F2:  f2_r  <= fin_res;
        DST_T:   tmp_r <= fin_res;
        DST_P2:  p2_r  <= fin_res;
        default: ;
      endcase
    end
    if (cmd.add_en && (cmd.aop == AOP_MSUB)) begin
      m_r <= add_res;
    end
  end

  // saturating adder operands
  always_comb begin
    add_x = tmp_r;
    add_y = p2_r;
    case (cmd.aop)
      AOP_FORCE: begin
        case (cmd.aidx)
          2'd0:    begin add_x = fsx_r; add_y = f0_r; end
          2'd1:    begin add_x = fsy_r; add_y = f1_r; end
          default: begin add_x = fsz_r; add_y = f2_r; end
        endcase
      end
      AOP_MOMENT: begin
        add_y = m_r;
        case (cmd.aidx)
          2'd0:    add_x = msx_r;
          2'd1:    add_x = msy_r;
          default: add_x = msz_r;
        endcase
      end
      default: begin
        add_x = tmp_r;
        add_y = p2_r;
      end
    endcase
  end

  assign add_wide = (cmd.aop == AOP_MSUB) ? {add_x[SUM_W-1], add_x} - {add_y[SUM_W-1], add_y}
                                          : {add_x[SUM_W-1], add_x} + {add_y[SUM_W-1], add_y};
  assign add_ovf  = add_wide[SUM_W] != add_wide[SUM_W-1];
  assign add_res  = add_ovf ? (add_wide[SUM_W] ? SUM_MIN : SUM_MAX) : add_wide[SUM_W-1:0];

  // sums and saturation flag, cleared when the totals leave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsx_r <= '0;
      fsy_r <= '0;
      fsz_r <= '0;
      msx_r <= '0;
      msy_r <= '0;
      msz_r <= '0;
      sat_r <= 1'b0;
    end else if (cmd.emit) begin
      fsx_r <= '0;
      fsy_r <= '0;
      fsz_r <= '0;
      msx_r <= '0;
      msy_r <= '0;
      msz_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (cmd.add_en && (cmd.aop == AOP_FORCE)) begin
        case (cmd.aidx)
          2'd0:    fsx_r <= add_res;
          2'd1:    fsy_r <= add_res;
          default: fsz_r <= add_res;
        endcase
      end
      if (cmd.add_en && (cmd.aop == AOP_MOMENT)) begin
        case (cmd.aidx)
          2'd0:    msx_r <= add_res;
          2'd1:    msy_r <= add_res;
          default: msz_r <= add_res;
        endcase
      end
      if ((cmd.mul_fin && !fin_fits) || (cmd.add_en && add_ovf)) begin
        sat_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.force_x  <= fsx_r;
      out_r.force_y  <= fsy_r;
      out_r.force_z  <= fsz_r;
      out_r.moment_x <= msx_r;
      out_r.moment_y <= msy_r;
      out_r.moment_z <= msz_r;
      out_r.overflow <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.last_face = last_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

### sv/pressure_force_moment_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_force_moment_accumulator
// Sums pressure force rho*(p - pRef)*S and moment (c - cofR) x force over
// the faces of a patch into saturating Q48.16 totals.
// ----------------------------------------------------------------------------
// A new face request is accepted only once the previous face is finished,
// and a face marked last then moves the totals into the output register,
// waiting only if the previous totals have not yet been taken. The pace is
// set by the single shared 33x33 multiplier: ten products per face, each
// built from two partial products plus a combine, shift and saturate step,
// then nine saturating adds on one shared adder. The totals wait in an
// output register, so new faces are accepted while a result is still pending.
// Configuration is to be written through the cfg port only while the block
// is idle, not enforced by the block; unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module pressure_force_moment_accumulator import pfma_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pfma_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfma_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  pfma_cmd_t cmd;
  pfma_sts_t sts;

  // sequencer
  pfma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  pfma_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
